// ===== rtl/mps_pkg.sv =====
// Shared types and codes for the memory pattern scanner.
// No dependencies; imported by every module of the block.
package mps_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [62:0] t_addr;

    localparam int ADDR_W = 63;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;

    // scan modes
    localparam logic [1:0] MODE_CHAR = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_STR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_VALUE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NUMERIC_VALUE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ADDR    = 3'd6;

    // per-cell control from the scanner
    typedef struct packed {
        logic shift;   // an item is accepted this cycle
        logic active;  // cell lies inside the pattern length
    } t_cell_ctrl;

endpackage

// ===== rtl/mps_in_if.sv =====
// Input channel of the scanner: one memory byte per item.
// Depends on mps_pkg for the byte type.
interface mps_in_if
    import mps_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/mps_out_if.sv =====
// Output channel of the scanner: one match address per item.
// Depends on mps_pkg for the address type.
interface mps_out_if
    import mps_pkg::*;
();
    logic  valid;
    logic  ready;
    t_addr match_address;

    modport source (output valid, output match_address, input ready);
    modport sink   (input valid, input match_address, output ready);
endinterface

// ===== rtl/memory_pattern_scanner.sv =====
// Memory pattern scanner: one byte per cycle while the input is not stalled.
// A match address is written to the output register in the cycle after the accepting byte.
// Throughput 1 item per cycle; the input stalls only while a result waits.
// Window is a chain of PATTERN_MAX cells compared in parallel.
// Synchronous active-low reset sets config to its defaults and clears fill count and output valid.
// Uses mps_pkg, mps_in_if, mps_out_if and mps_cell.
module memory_pattern_scanner
    import mps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    mps_in_if.sink                 i_in,
    mps_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PD = 2 ** IW;

    // configuration
    logic [1:0]  r_scan_mode;
    t_byte       r_char_value;
    logic [31:0] r_numeric_value;
    logic [63:0] r_pattern_low;
    logic [63:0] r_pattern_high;
    logic [4:0]  r_pattern_len;
    t_addr       r_start_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode     <= MODE_CHAR;
            r_char_value    <= '0;
            r_numeric_value <= '0;
            r_pattern_low   <= '0;
            r_pattern_high  <= '0;
            r_pattern_len   <= 5'd1;
            r_start_addr    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCAN_MODE:     r_scan_mode     <= i_cfg_data[1:0];
                REG_CHAR_VALUE:    r_char_value    <= i_cfg_data[7:0];
                REG_NUMERIC_VALUE: r_numeric_value <= i_cfg_data[31:0];
                REG_PATTERN_LOW:   r_pattern_low   <= i_cfg_data;
                REG_PATTERN_HIGH:  r_pattern_high  <= i_cfg_data;
                REG_PATTERN_LEN:   r_pattern_len   <= i_cfg_data[4:0];
                REG_START_ADDR:    r_start_addr    <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the pattern length into 1..PATTERN_MAX
    logic [LW-1:0] used_len;
    always_comb begin
        if (r_pattern_len == 5'd0) begin
            used_len = LW'(1);
        end else if (r_pattern_len > 5'(PATTERN_MAX)) begin
            used_len = LW'(PATTERN_MAX);
        end else begin
            used_len = r_pattern_len[LW-1:0];
        end
    end

    // pattern bytes, byte 0 first
    t_byte pat [PD];
    for (genvar j = 0; j < PD; j++) begin : g_pat
        if (j < 8) begin : g_low
            assign pat[j] = r_pattern_low[j*8 +: 8];
        end else begin : g_high
            assign pat[j] = r_pattern_high[(j-8)*8 +: 8];
        end
    end

    // handshake: one output register parts the two sides
    logic  r_out_valid;
    t_addr r_out_addr;
    logic  accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // window chain
    t_byte chain_in  [PATTERN_MAX];
    t_byte chain_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        t_cell_ctrl    ctrl;
        logic [LW-1:0] pat_idx;

        if (k == 0) begin : g_head
            assign chain_in[k] = i_in.data_byte;
        end else begin : g_link
            assign chain_in[k] = chain_out[k-1];
        end

        // newest byte at cell 0 meets the last pattern byte
        assign pat_idx     = used_len - LW'(k + 1);
        assign ctrl.shift  = accept;
        assign ctrl.active = (LW'(k) < used_len);

        mps_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_byte     (chain_in[k]),
            .i_pat_byte (pat[pat_idx[IW-1:0]]),
            .o_byte     (chain_out[k]),
            .o_hit      (cell_hit[k])
        );
    end

    // scan position
    logic [LW-1:0] r_fill;
    t_addr         r_addr;
    logic [LW-1:0] fill_next;
    t_addr         base_addr;
    t_addr         hit_addr;
    logic          hit;

    assign fill_next = (r_fill == LW'(PATTERN_MAX)) ? r_fill : r_fill + LW'(1);
    assign base_addr = (r_fill == '0) ? r_start_addr : r_addr;

    always_comb begin
        hit      = 1'b0;
        hit_addr = base_addr;
        unique case (r_scan_mode)
            MODE_CHAR: hit = (i_in.data_byte == r_char_value);
            MODE_NUM: begin
                // only 1..127 can equal a signed byte that is also positive
                hit = (r_numeric_value[31:7] == '0) && (r_numeric_value[6:0] != '0)
                      && (i_in.data_byte == {1'b0, r_numeric_value[6:0]});
            end
            MODE_STR: begin
                hit      = (fill_next >= used_len) && (&cell_hit);
                hit_addr = base_addr - ADDR_W'(used_len - LW'(1));
            end
            default: hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= i_in.last_byte ? '0 : fill_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= base_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= hit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hit) begin
            r_out_addr <= hit_addr;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.match_address = r_out_addr;
endmodule

// ===== rtl/mps_cell.sv =====
// One window cell: holds one recent byte, passes it on to the next cell
// and compares the byte it takes in with its pattern byte. Uses mps_pkg.
module mps_cell
    import mps_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_byte      i_byte,
    input  t_byte      i_pat_byte,
    output t_byte      o_byte,
    output logic       o_hit
);
    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    // inactive cells never veto a match
    assign o_hit  = !i_ctrl.active || (i_byte == i_pat_byte);
endmodule

// ===== rtl/mps_checker.sv =====
// Port-level checks for the memory pattern scanner, bound to the top level.
// Depends on mps_pkg and on memory_pattern_scanner's ports.
module mps_checker
    import mps_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_addr i_match_address
);
    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled item dropped");

    a_hold_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_match_address))
        else $error("stalled item changed");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while result waits");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !in_acc |=> !i_out_valid)
        else $error("result without an input item");
endmodule

bind memory_pattern_scanner mps_checker u_mps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_match_address (o_out.match_address)
);

// ===== test/tb_memory_pattern_scanner.sv =====
`timescale 1ns / 100ps
// Testbench for memory_pattern_scanner: directed and random byte streams in all modes.
// Depends on mps_pkg, mps_in_if, mps_out_if and the scanner RTL.
module tb_memory_pattern_scanner;
    import mps_pkg::*;

    localparam int         PATTERN_MAX = 16;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mps_in_if  in_ch();
    mps_out_if out_ch();

    memory_pattern_scanner #(.PATTERN_MAX(PATTERN_MAX)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // register shadows
    logic [1:0]  mode_reg = MODE_CHAR;
    t_byte       char_reg = 8'h00;
    logic [31:0] num_reg = 32'h0;
    logic [63:0] pat_lo_reg = 64'h0;
    logic [63:0] pat_hi_reg = 64'h0;
    logic [4:0]  len_reg = 5'd1;
    t_addr       start_reg = '0;

    // scan state as the block should hold it
    t_addr scan_addr = '0;
    t_byte scan_win [PATTERN_MAX];
    int    scan_fill = 0;

    t_addr pending_match_addrs [$];
    int    fail_count = 0;
    int    tx_idle_pct = 0;
    int    rx_stall_pct = 0;
    int    rx_hold = 0;
    t_byte alph [3];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb_memory_pattern_scanner: FAIL");
        $finish;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    function automatic int pattern_span();
        if (len_reg == 5'd0) begin
            return 1;
        end
        return (len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
    endfunction

    function automatic t_byte pattern_byte(input int i);
        logic [127:0] pat;
        pat = {pat_hi_reg, pat_lo_reg};
        return pat[8*i +: 8];
    endfunction

    // Advance the scan state by one accepted byte and queue any match address.
    task automatic scan_byte(input t_byte b, input logic last);
        logic  hit;
        t_addr at;
        int    n;
        if (scan_fill == 0) begin
            scan_addr = start_reg;
        end
        at = scan_addr;
        for (int i = PATTERN_MAX - 1; i > 0; i--) begin
            scan_win[i] = scan_win[i-1];
        end
        scan_win[0] = b;
        if (scan_fill < PATTERN_MAX) begin
            scan_fill++;
        end
        hit = 1'b0;
        case (mode_reg)
            MODE_CHAR: begin
                hit = (b == char_reg);
            end
            MODE_NUM: begin
                hit = (num_reg >= 32'd1) && (num_reg <= 32'd127) && (b == num_reg[7:0]);
            end
            MODE_STR: begin
                n = pattern_span();
                if (scan_fill >= n) begin
                    hit = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        if (scan_win[n-1-i] != pattern_byte(i)) begin
                            hit = 1'b0;
                        end
                    end
                    if (hit) begin
                        at = at - t_addr'(n - 1);
                    end
                end
            end
            default: ;
        endcase
        scan_addr = scan_addr + t_addr'(1);
        if (last) begin
            foreach (scan_win[i]) scan_win[i] = 8'h00;
            scan_fill = 0;
            scan_addr = start_reg;
        end
        if (hit) begin
            pending_match_addrs = {pending_match_addrs, at};
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            REG_SCAN_MODE:     mode_reg = value[1:0];
            REG_CHAR_VALUE:    char_reg = value[7:0];
            REG_NUMERIC_VALUE: num_reg = value[31:0];
            REG_PATTERN_LOW:   pat_lo_reg = value;
            REG_PATTERN_HIGH:  pat_hi_reg = value;
            REG_PATTERN_LEN:   len_reg = value[4:0];
            REG_START_ADDR:    start_reg = value[62:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    // Offer one item, idling first at the sender's rate, and hold it until taken.
    task automatic send_byte(input t_byte b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        scan_byte(b, last);
    endtask

    // Drop valid, wait for every queued match, then let the pipeline settle.
    task automatic wait_matches_drained();
        in_ch.valid <= 1'b0;
        while (pending_match_addrs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_byte pick_byte();
        case (mode_reg)
            MODE_CHAR: if ($urandom_range(0, 9) < 3) return char_reg;
            MODE_NUM:  if ($urandom_range(0, 9) < 3) return num_reg[7:0];
            MODE_STR:  if ($urandom_range(0, 3) != 0) return alph[$urandom_range(0, 2)];
            default: ;
        endcase
        return t_byte'($urandom);
    endfunction

    task automatic test_char_mode();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_matches_drained();
        write_reg(REG_CHAR_VALUE, 64'hFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_matches_drained();
    endtask

    task automatic test_numeric_mode();
        write_reg(REG_SCAN_MODE, {62'h0, MODE_NUM});
        write_reg(REG_NUMERIC_VALUE, 64'd127);
        send_byte(8'h7F, 1'b0);
        wait_matches_drained();
        // negative value: the byte 0xFF reads as -1 but must not match
        write_reg(REG_NUMERIC_VALUE, 64'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        wait_matches_drained();
        write_reg(REG_NUMERIC_VALUE, 64'd1);
        send_byte(8'h01, 1'b1);
        wait_matches_drained();
    endtask

    task automatic test_string_mode();
        write_reg(REG_SCAN_MODE, {62'h0, MODE_STR});
        write_reg(REG_PATTERN_LOW, 64'h43_42_41);
        write_reg(REG_PATTERN_LEN, 64'd3);
        // short window first, then a match starting two bytes back
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);
        wait_matches_drained();
        // zero length behaves as one byte
        write_reg(REG_PATTERN_LEN, 64'd0);
        write_reg(REG_PATTERN_LOW, 64'h55);
        send_byte(8'h55, 1'b1);
        wait_matches_drained();
    endtask

    task automatic test_unused_mode();
        write_reg(REG_SCAN_MODE, {62'h0, MODE_UNUSED});
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_matches_drained();
    endtask

    task automatic test_address_wrap();
        write_reg(REG_SCAN_MODE, {62'h0, MODE_CHAR});
        write_reg(REG_CHAR_VALUE, 64'h11);
        write_reg(REG_START_ADDR, 64'h7FFF_FFFF_FFFF_FFFE);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b1);
        wait_matches_drained();
        // match start computed back across the wrap
        write_reg(REG_SCAN_MODE, {62'h0, MODE_STR});
        write_reg(REG_PATTERN_LOW, 64'h11_11);
        write_reg(REG_PATTERN_LEN, 64'd2);
        write_reg(REG_START_ADDR, 64'h7FFF_FFFF_FFFF_FFFF);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b1);
        wait_matches_drained();
        // a new start address only applies from the next scan
        write_reg(REG_SCAN_MODE, {62'h0, MODE_CHAR});
        write_reg(REG_START_ADDR, 64'd5);
        send_byte(8'h11, 1'b0);
        wait_matches_drained();
        write_reg(REG_START_ADDR, 64'd100);
        send_byte(8'h11, 1'b1);
        send_byte(8'h11, 1'b1);
        wait_matches_drained();
    endtask

    task automatic test_random_phase(input int p);
        int           pick;
        int           n;
        int           sent;
        int           scan_len;
        int           k;
        logic [1:0]   mode_v;
        logic [4:0]   len_v;
        logic [31:0]  num_v;
        logic [127:0] pat;
        t_addr        start_v;
        wait_matches_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pick = $urandom_range(0, 9);
        mode_v = (pick < 2) ? MODE_CHAR : (pick < 4) ? MODE_NUM :
                 (pick < 9) ? MODE_STR : MODE_UNUSED;
        case ($urandom_range(0, 9))
            0: len_v = 5'd0;
            1: len_v = 5'd1;
            2: len_v = 5'd16;
            3: len_v = 5'($urandom_range(17, 31));
            4: len_v = 5'($urandom_range(6, 16));
            default: len_v = 5'($urandom_range(2, 5));
        endcase
        // pin a few phases so the char, numeric and string modes and the long lengths are always reached
        case (p)
            0: mode_v = MODE_CHAR;
            1: begin mode_v = MODE_STR; len_v = 5'($urandom_range(17, 31)); end
            2: begin mode_v = MODE_STR; len_v = 5'd16; end
            3: mode_v = MODE_NUM;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: num_v = 32'd0;
            1: num_v = 32'd128;
            2: num_v = 32'hFFFF_FFFF;
            3: num_v = 32'h8000_0000;
            4: num_v = $urandom;
            default: num_v = 32'($urandom_range(1, 127));
        endcase
        case ($urandom_range(0, 5))
            0: start_v = '0;
            1: start_v = '1;
            2: start_v = t_addr'('1) - t_addr'($urandom_range(0, 40));
            default: start_v = t_addr'({$urandom, $urandom});
        endcase
        n = (len_v == 5'd0) ? 1 : (len_v > PATTERN_MAX) ? PATTERN_MAX : int'(len_v);
        foreach (alph[i]) alph[i] = t_byte'($urandom);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pat[8*i +: 8] = (i < n) ? alph[$urandom_range(0, 2)] : t_byte'($urandom);
        end
        // upper data bits carry junk that the registers must ignore
        write_reg(REG_SCAN_MODE, {$urandom, 30'($urandom), mode_v});
        write_reg(REG_CHAR_VALUE, {$urandom, 24'($urandom), 8'($urandom)});
        write_reg(REG_NUMERIC_VALUE, {$urandom, num_v});
        write_reg(REG_PATTERN_LOW, pat[63:0]);
        write_reg(REG_PATTERN_HIGH, pat[127:64]);
        write_reg(REG_PATTERN_LEN, {$urandom, 27'($urandom), len_v});
        write_reg(REG_START_ADDR, {1'($urandom), start_v});
        case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
            default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
        endcase
        sent = 0;
        while (sent < 45) begin
            scan_len = $urandom_range(1, 40);
            k = 0;
            while (k < scan_len) begin
                if (mode_reg == MODE_STR && $urandom_range(0, 5) == 0 && k + n <= scan_len) begin
                    // plant the whole pattern
                    for (int j = 0; j < n; j++) begin
                        send_byte(pattern_byte(j), k == scan_len - 1);
                        k++;
                    end
                end else begin
                    send_byte(pick_byte(), k == scan_len - 1);
                    k++;
                end
            end
            sent += scan_len;
        end
    endtask

    // Hold the output off long enough for the block to back up into its input.
    task automatic test_output_backpressure();
        wait_matches_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_reg(REG_SCAN_MODE, {62'h0, MODE_CHAR});
        write_reg(REG_CHAR_VALUE, 64'hA5);
        rx_hold = 80;
        for (int i = 0; i < 40; i++) begin
            send_byte(($urandom_range(0, 1) != 0) ? 8'hA5 : t_byte'($urandom), i == 39);
        end
        wait_matches_drained();
    endtask

    task automatic test_sender_pause();
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
        write_reg(REG_CHAR_VALUE, 64'h3C);
        for (int i = 0; i < 10; i++) begin
            send_byte(($urandom_range(0, 9) < 4) ? 8'h3C : t_byte'($urandom), 1'b0);
        end
        // pause mid-scan until every match is out
        wait_matches_drained();
        for (int i = 0; i < 10; i++) begin
            send_byte(($urandom_range(0, 9) < 4) ? 8'h3C : t_byte'($urandom), i == 9);
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_matches
        t_addr want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_match_addrs.size() == 0) begin
                note_failure($sformatf("unexpected match_address %h", out_ch.match_address));
            end else begin
                want = pending_match_addrs.pop_front();
                if (out_ch.match_address !== want) begin
                    note_failure($sformatf("match_address expected %h, got %h",
                                           want, out_ch.match_address));
                end
            end
        end
    end

    initial begin
        foreach (scan_win[i]) scan_win[i] = 8'h00;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_char_mode();
        test_numeric_mode();
        test_string_mode();
        test_unused_mode();
        test_address_wrap();
        for (int p = 0; p < 15; p++) begin
            test_random_phase(p);
        end
        test_output_backpressure();
        test_sender_pause();
        wait_matches_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_match_addrs.size() == 0) begin
            $display("tb_memory_pattern_scanner: PASS");
        end else begin
            $display("tb_memory_pattern_scanner: FAIL");
        end
        $finish;
    end

endmodule
